// File: hdl/rsproj_pkg.sv
// shared types and constants of the road segment projector
package rsproj_pkg;

   localparam int CsrIdxW = 2;
   localparam logic [CsrIdxW-1:0] CSR_CAMERA_DEPTH    = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_ROAD_HALF_WIDTH = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_SCREEN_WIDTH    = 2'd2;
   localparam logic [CsrIdxW-1:0] CSR_SCREEN_HEIGHT   = 2'd3;

   localparam logic [15:0] RST_CAMERA_DEPTH    = 16'd55050;
   localparam logic [15:0] RST_ROAD_HALF_WIDTH = 16'd3000;
   localparam logic [11:0] RST_SCREEN_WIDTH    = 12'd1980;
   localparam logic [11:0] RST_SCREEN_HEIGHT   = 12'd1080;

   localparam int DivSteps = 32;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_DIV  = 6'b000010,
      ST_MUL1 = 6'b000100,
      ST_MUL2 = 6'b001000,
      ST_MUL3 = 6'b010000,
      ST_FIN  = 6'b100000
   } state_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic mul1;
      logic mul2;
      logic mul3;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic ok;
      logic div_last;
      logic out_free;
   } stat_type;

endpackage

// File: hdl/rsproj_ctrl.sv
// sequencer of the road segment projector
module rsproj_ctrl
   import rsproj_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (!stat.ok) begin
               state_in = ST_FIN;
            end else begin
               cmd.div_step = 1'b1;
               if (stat.div_last) state_in = ST_MUL1;
            end
         end
         ST_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = ST_MUL3;
         end
         ST_MUL3: begin
            cmd.mul3 = 1'b1;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (stat.out_free) begin
               cmd.commit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// File: hdl/rsproj_dp.sv
// datapath of the road segment projector: accumulators, divider, scaling, culling
module rsproj_dp
   import rsproj_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [15:0]        csr_wdata,
   input  logic [111:0]       req_tdata,
   input  logic               req_tuser,
   output logic [95:0]        rsp_tdata,
   output logic               rsp_tuser,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  cmd_type            cmd,
   output stat_type           stat
);

   logic [15:0] cd_ff, rhw_ff;
   logic [11:0] sw_ff, sh_ff;

   logic signed [31:0] xoff_ff, xoff_in;
   logic signed [15:0] xslope_ff, xslope_in;
   logic signed [15:0] nearest_ff, lastx_ff, lasty_ff;
   logic [15:0]        lastw_ff;
   logic               lastv_ff;

   logic [32:0] magx_ff;
   logic [17:0] magy_ff;
   logic        negx_ff, negy_ff, ok_ff;
   logic [24:0] dvs_ff;

   logic [31:0] num_ff, quo_ff;
   logic [25:0] rem_ff;
   logic [4:0]  cnt_ff;

   logic [63:0] px_ff;
   logic [49:0] py_ff;
   logic [47:0] pw_ff;
   logic [33:0] qx_ff, qy_ff;
   logic [31:0] qw_ff;
   logic [45:0] rx_ff;
   logic [44:0] ry_ff;
   logic [43:0] rw_ff;

   logic [95:0] out_data_ff;
   logic        out_vis_ff, out_valid_ff;

   logic signed [16:0] cam_x, cam_h, seg_y;
   logic [24:0]        cam_z, seg_z;
   logic signed [3:0]  seg_curve;
   logic signed [31:0] xo_base;
   logic signed [15:0] xs_base;
   logic signed [32:0] osum;
   logic signed [16:0] ssum;
   logic signed [33:0] dx;
   logic signed [17:0] dy;
   logic [25:0]        rz;
   logic [25:0]        trial;
   logic [48:0]        qx_full;
   logic [10:0]        h2;
   logic [28:0]        offx, offy;
   logic [26:0]        offw;
   logic signed [30:0] cx_full, cy_full;
   logic signed [15:0] cx, cy;
   logic [15:0]        cw;
   logic               vis;

   function automatic logic signed [15:0] sat16(input logic signed [30:0] v);
      if (v > 31'sd32767) return 16'sh7fff;
      else if (v < -31'sd32768) return 16'sh8000;
      else return v[15:0];
   endfunction

   assign cam_x     = req_tdata[16:0];
   assign cam_h     = req_tdata[33:17];
   assign cam_z     = req_tdata[58:34];
   assign seg_y     = req_tdata[75:59];
   assign seg_z     = req_tdata[100:76];
   assign seg_curve = req_tdata[104:101];

   always_comb begin
      xo_base = req_tuser ? 32'sd0 : xoff_ff;
      xs_base = req_tuser ? 16'sd0 : xslope_ff;
      osum = 33'(xo_base) + 33'(xs_base);
      if (osum > 33'sh0_7fff_ffff) xoff_in = 32'sh7fff_ffff;
      else if (osum < -33'sh0_8000_0000) xoff_in = 32'sh8000_0000;
      else xoff_in = osum[31:0];
      ssum = 17'(xs_base) + 17'(seg_curve);
      if (ssum > 17'sd32767) xslope_in = 16'sh7fff;
      else if (ssum < -17'sd32768) xslope_in = 16'sh8000;
      else xslope_in = ssum[15:0];
      dx = 34'(xoff_in) - 34'(cam_x);
      dy = 18'(seg_y) - 18'(cam_h);
      rz = {1'b0, seg_z} - {1'b0, cam_z};
   end

   assign trial = {rem_ff[24:0], num_ff[31]};
   assign qx_full = (magx_ff[32] ? {1'b0, quo_ff, 16'd0} : 49'd0) + {1'b0, px_ff[63:16]};
   assign h2 = sh_ff[11:1];

   always_comb begin
      offx = rx_ff[45:17];
      offy = ry_ff[44:16];
      offw = rw_ff[43:17];
      cx_full = negx_ff ? 31'(sw_ff[11:1]) - 31'(offx) : 31'(sw_ff[11:1]) + 31'(offx);
      cy_full = negy_ff ? 31'(h2) + 31'(offy) : 31'(h2) - 31'(offy);
      if (ok_ff) begin
         cx = sat16(cx_full);
         cy = sat16(cy_full);
         cw = (|offw[26:16]) ? 16'hffff : offw[15:0];
      end else begin
         cx = '0;
         cy = '0;
         cw = '0;
      end
      vis = ok_ff && lastv_ff && !cy[15] && !lasty_ff[15] && (cy < nearest_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cd_ff  <= RST_CAMERA_DEPTH;
         rhw_ff <= RST_ROAD_HALF_WIDTH;
         sw_ff  <= RST_SCREEN_WIDTH;
         sh_ff  <= RST_SCREEN_HEIGHT;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CAMERA_DEPTH:    cd_ff  <= csr_wdata;
            CSR_ROAD_HALF_WIDTH: rhw_ff <= csr_wdata;
            CSR_SCREEN_WIDTH:    sw_ff  <= csr_wdata[11:0];
            CSR_SCREEN_HEIGHT:   sh_ff  <= csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         xoff_ff    <= '0;
         xslope_ff  <= '0;
         nearest_ff <= 16'(RST_SCREEN_HEIGHT);
         lastx_ff   <= '0;
         lasty_ff   <= '0;
         lastw_ff   <= '0;
         lastv_ff   <= 1'b0;
         ok_ff      <= 1'b0;
      end else if (cmd.load) begin
         xoff_ff   <= xoff_in;
         xslope_ff <= xslope_in;
         ok_ff     <= !rz[25] && (rz != 26'd0);
         if (req_tuser) begin
            nearest_ff <= 16'(sh_ff);
            lastx_ff   <= '0;
            lasty_ff   <= '0;
            lastw_ff   <= '0;
            lastv_ff   <= 1'b0;
         end
      end else if (cmd.commit) begin
         if (vis) nearest_ff <= cy;
         lastx_ff <= cx;
         lasty_ff <= cy;
         lastw_ff <= cw;
         lastv_ff <= ok_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         magx_ff <= dx[33] ? 33'(-dx) : dx[32:0];
         negx_ff <= dx[33];
         magy_ff <= dy[17] ? 18'(-dy) : dy;
         negy_ff <= dy[17];
         dvs_ff  <= rz[24:0];
         num_ff  <= {cd_ff, 16'd0};
         rem_ff  <= '0;
         quo_ff  <= '0;
         cnt_ff  <= '0;
      end else if (cmd.div_step) begin
         num_ff <= {num_ff[30:0], 1'b0};
         cnt_ff <= cnt_ff + 5'd1;
         if (trial >= {1'b0, dvs_ff}) begin
            rem_ff <= trial - {1'b0, dvs_ff};
            quo_ff <= {quo_ff[30:0], 1'b1};
         end else begin
            rem_ff <= trial;
            quo_ff <= {quo_ff[30:0], 1'b0};
         end
      end
      if (cmd.mul1) begin
         px_ff <= quo_ff * magx_ff[31:0];
         py_ff <= quo_ff * magy_ff;
         pw_ff <= quo_ff * rhw_ff;
      end
      if (cmd.mul2) begin
         qx_ff <= (|qx_full[48:34]) ? '1 : qx_full[33:0];
         qy_ff <= py_ff[49:16];
         qw_ff <= pw_ff[47:16];
      end
      if (cmd.mul3) begin
         rx_ff <= qx_ff * sw_ff;
         ry_ff <= qy_ff * h2;
         rw_ff <= qw_ff * sw_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         out_data_ff <= {lastw_ff, lasty_ff, lastx_ff, cw, cy, cx};
         out_vis_ff  <= vis;
      end
   end

   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_vis_ff;
   assign rsp_tvalid = out_valid_ff;

   assign stat.ok       = ok_ff;
   assign stat.div_last = (cnt_ff == 5'(DivSteps - 1));
   assign stat.out_free = !out_valid_ff || rsp_tready;

endmodule

// File: hdl/road_segment_projector.sv
// top level of the road segment projector
// Projects one road segment per input word into screen column, row and half width,
// and reports the previous projection and whether the quad between them is drawn.
// A segment in front of the camera runs through the 32-step radix-2 divider for the
// perspective scale, then through the multiply, rescale and multiply states MUL1, MUL2
// and MUL3; a segment at or behind the camera skips them. The input is ready again the
// cycle after the result is registered. One segment is in work at a time; the next is
// accepted while a finished result waits on rsp, and a result only stalls the block
// when the previous one is still unaccepted at the end of the work.
// The user must write configuration only while no segment is in work; the block
// itself does not enforce it.
module road_segment_projector
   import rsproj_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [15:0]        csr_wdata,
   input  logic               req_tvalid,
   output logic               req_tready,
   // cam_x, cam_h, cam_z, seg_y, seg_z, seg_curve, zero fill
   input  logic [111:0]       req_tdata,
   // frame_start
   input  logic               req_tuser,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   // screen_x, screen_y, half_w, prev_screen_x, prev_screen_y, prev_half_w
   output logic [95:0]        rsp_tdata,
   // visible
   output logic               rsp_tuser
);

   cmd_type  cmd;
   stat_type stat;

   rsproj_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   rsproj_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule

// File: sim/tb_road_segment_projector.sv
// testbench of the road segment projector: directed and random segment streams against a predictor
`timescale 1ns / 1ps

module tb_road_segment_projector;
   import rsproj_pkg::*;

   localparam int CycleLimit = 1000000;
   localparam int DrainCycles = 60;

   typedef struct {
      bit                 fs;
      logic signed [16:0] cam_x;
      logic signed [16:0] cam_h;
      logic [24:0]        cam_z;
      logic signed [16:0] seg_y;
      logic [24:0]        seg_z;
      logic signed [3:0]  curve;
   } segment_type;

   typedef struct {
      logic [15:0] sx, sy, hw, psx, psy, phw;
      logic        vis;
   } projection_type;

   class projection_board;
      longint unsigned depth, rhw, sw, sh;
      longint          x_off, x_slope, nearest, lx, ly, lw;
      bit              lvalid;
      projection_type  awaited[$];
      int              errors;

      function new();
         depth = RST_CAMERA_DEPTH;
         rhw = RST_ROAD_HALF_WIDTH;
         sw = RST_SCREEN_WIDTH;
         sh = RST_SCREEN_HEIGHT;
         errors = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         x_off = 0;
         x_slope = 0;
         nearest = longint'(sh);
         lx = 0;
         ly = 0;
         lw = 0;
         lvalid = 0;
      endfunction

      function void write_reg(logic [CsrIdxW-1:0] idx, logic [15:0] val);
         case (idx)
            CSR_CAMERA_DEPTH: depth = val;
            CSR_ROAD_HALF_WIDTH: rhw = val;
            CSR_SCREEN_WIDTH: sw = val[11:0];
            CSR_SCREEN_HEIGHT: sh = val[11:0];
            default: ;
         endcase
      endfunction

      function longint clamp(longint v, longint lo, longint hi);
         return v < lo ? lo : (v > hi ? hi : v);
      endfunction

      function longint unsigned scaled(longint unsigned s, longint unsigned m);
         return ((s * (m >> 32)) << 16) + ((s * (m & 64'hFFFF_FFFF)) >> 16);
      endfunction

      function longint unsigned magn(longint v);
         return v < 0 ? longint'(-v) : v;
      endfunction

      function void note(segment_type g);
         projection_type  p;
         longint          cx, cy, cw, rz, dx, dy, offx, offy;
         longint unsigned s, h2, hwu;
         bit              ok;
         cx = 0; cy = 0; cw = 0; ok = 0;
         if (g.fs) clear_frame();
         x_off = clamp(x_off + x_slope, -64'sd2147483648, 64'sd2147483647);
         x_slope = clamp(x_slope + longint'(g.curve), -32768, 32767);
         p.psx = lvalid ? lx[15:0] : 16'd0;
         p.psy = lvalid ? ly[15:0] : 16'd0;
         p.phw = lvalid ? lw[15:0] : 16'd0;
         rz = longint'(g.seg_z) - longint'(g.cam_z);
         if (rz > 0) begin
            s = (depth << 16) / longint'(rz);
            h2 = sh >> 1;
            dx = x_off - longint'(g.cam_x);
            dy = longint'(g.seg_y) - longint'(g.cam_h);
            offx = longint'((scaled(s, magn(dx)) * sw) >> 17);
            offy = longint'((scaled(s, magn(dy)) * h2) >> 16);
            hwu = (scaled(s, rhw) * sw) >> 17;
            cx = longint'(sw >> 1) + (dx < 0 ? -offx : offx);
            cy = longint'(h2) - (dy < 0 ? -offy : offy);
            cx = clamp(cx, -32768, 32767);
            cy = clamp(cy, -32768, 32767);
            cw = hwu > 65535 ? 65535 : longint'(hwu);
            ok = 1;
         end
         p.vis = 0;
         if (ok && lvalid && cy >= 0 && ly >= 0 && cy < nearest) begin
            p.vis = 1;
            nearest = cy;
         end
         lx = cx; ly = cy; lw = cw; lvalid = ok;
         p.sx = cx[15:0];
         p.sy = cy[15:0];
         p.hw = cw[15:0];
         awaited.push_back(p);
      endfunction

      function void compare(string name, logic [15:0] exp_v, logic [15:0] act_v);
         if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            errors++;
         end
      endfunction

      function void check(logic [95:0] d, logic u);
         projection_type p;
         if (awaited.size() == 0) begin
            $error("unexpected word: %0h", d);
            errors++;
            return;
         end
         p = awaited.pop_front();
         compare("screen_x", p.sx, d[15:0]);
         compare("screen_y", p.sy, d[31:16]);
         compare("half_w", p.hw, d[47:32]);
         compare("prev_screen_x", p.psx, d[63:48]);
         compare("prev_screen_y", p.psy, d[79:64]);
         compare("prev_half_w", p.phw, d[95:80]);
         compare("visible", 16'(p.vis), 16'(u));
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               csr_we;
   logic [CsrIdxW-1:0] csr_index;
   logic [15:0]        csr_wdata;
   logic               req_tvalid;
   logic               req_tready;
   logic [111:0]       req_tdata;
   logic               req_tuser;
   logic               rsp_tvalid;
   logic               rsp_tready;
   logic [95:0]        rsp_tdata;
   logic               rsp_tuser;

   projection_board board = new();
   int  cycles = 0;
   int  stall_left = 0;
   bit  long_hold = 0;
   bit  busy_mode = 0;

   road_segment_projector u_top (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("status: fail");
         $finish;
      end
   end

   // result side: random stalls, one long hold-off on request
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check(rsp_tdata, rsp_tuser);
      if (long_hold) begin
         long_hold = 0;
         stall_left <= 400;
         rsp_tready <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 0;
      end else if (!busy_mode && $urandom_range(0, 99) < 25) begin
         stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                    : $urandom_range(1, 3);
         rsp_tready <= 0;
      end else begin
         rsp_tready <= 1;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (busy_mode || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send(segment_type g);
      int gap;
      req_tvalid <= 1;
      req_tuser <= g.fs;
      req_tdata <= {7'd0, g.curve, g.seg_z, g.seg_y, g.cam_z, g.cam_h, g.cam_x};
      do @(posedge clock); while (!req_tready);
      board.note(g);
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic settle();
      req_tvalid <= 0;
      @(posedge clock);
      while (board.awaited.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_reg(logic [CsrIdxW-1:0] idx, logic [15:0] val);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      board.write_reg(idx, val);
      @(posedge clock);
      csr_we <= 0;
      @(posedge clock);
   endtask

   task automatic configure(logic [15:0] d, logic [15:0] r, logic [15:0] w, logic [15:0] h);
      settle();
      write_reg(CSR_CAMERA_DEPTH, d);
      write_reg(CSR_ROAD_HALF_WIDTH, r);
      write_reg(CSR_SCREEN_WIDTH, w);
      write_reg(CSR_SCREEN_HEIGHT, h);
   endtask

   function automatic segment_type seg(bit fs, int cx, int ch, int cz, int sy, int sz, int cv);
      segment_type g;
      g.fs = fs;
      g.cam_x = 17'(cx);
      g.cam_h = 17'(ch);
      g.cam_z = 25'(cz);
      g.seg_y = 17'(sy);
      g.seg_z = 25'(sz);
      g.curve = 4'(cv);
      return g;
   endfunction

   task automatic directed();
      send(seg(1, 0, 1500, 0, 0, 1000, 0));
      send(seg(0, 0, 1500, 0, 0, 2000, 7));
      send(seg(0, 0, 1500, 0, 200, 3000, -8));
      send(seg(0, 0, 1500, 5000, 0, 5000, 3));
      send(seg(0, 0, 1500, 0, 0, 6000, 0));
      send(seg(0, 0, 1500, 0, 0, 7000, 0));
      send(seg(0, 0, 1500, 0, 0, 1500, 0));
      send(seg(0, -65536, 65535, 100, -65536, 101, -8));
      send(seg(0, 65535, -65536, 100, 65535, 101, 7));
      send(seg(0, 0, 0, 33554431, 0, 33554431, 0));
      send(seg(0, 0, 1000, 0, 0, 33554431, 7));
      send(seg(0, 100, 1000, 9000, 0, 200, 1));
      send(seg(1, 0, 1000, 33554431, 0, 0, -1));
      send(seg(1, 300, 2000, 1000, -500, 1200, 2));
      send(seg(0, 300, 2000, 1000, -500, 1300, -3));
      send(seg(0, 300, 65535, 1000, -65536, 1301, 0));
   endtask

   task automatic random_items(int count, int hold_at);
      segment_type g;
      int          n, left, span_z, cx, ch, cz;
      n = 0;
      while (n < count) begin
         if ($urandom_range(0, 9) == 0) busy_mode = !busy_mode;
         if ($urandom_range(0, 99) < 15) begin
            g = seg($urandom_range(0, 1), $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom);
            send(g);
            n++;
            if (n == hold_at) long_hold = 1;
         end else begin
            left = $urandom_range(3, 30);
            cx = $urandom_range(0, 4000) - 2000;
            ch = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(200, 3000);
            cz = $urandom_range(0, 33000000);
            span_z = $urandom_range(1, 300);
            for (int i = 0; i < left && n < count; i++) begin
               g = seg(i == 0, cx, ch, cz, $urandom_range(0, 1000) - 500, cz + span_z,
                       $urandom_range(0, 15) - 8);
               if ($urandom_range(0, 19) == 0) g.seg_z = 25'(cz - $urandom_range(0, 50));
               send(g);
               n++;
               if (n == hold_at) long_hold = 1;
               span_z += ($urandom_range(0, 4) == 0) ? $urandom_range(0, 200000)
                                                    : $urandom_range(1, 400);
            end
         end
      end
   endtask

   initial begin
      reset = 1;
      csr_we = 0;
      csr_index = CSR_CAMERA_DEPTH;
      csr_wdata = 0;
      req_tvalid = 0;
      req_tdata = 0;
      req_tuser = 0;
      rsp_tready = 0;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      directed();
      random_items(140, 60);
      configure(16'hFFFF, 16'hFFFF, 16'd4095, 16'd4095);
      directed();
      random_items(130, -1);
      configure(16'd0, 16'd0, 16'd1, 16'd1);
      random_items(100, -1);
      configure(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      random_items(140, -1);
      configure(16'($urandom_range(1, 65535)), 16'($urandom_range(0, 10000)),
                16'($urandom_range(1, 4095)), 16'($urandom_range(1, 4095)));
      random_items(140, -1);
      configure(RST_CAMERA_DEPTH, RST_ROAD_HALF_WIDTH, 16'(RST_SCREEN_WIDTH),
                16'(RST_SCREEN_HEIGHT));
      random_items(40, -1);
      settle();
      if (board.errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
